@@ rtl/front_middle_back_queue_macros.svh @@
// ============================================================================
// Front-middle-back queue assertion macros
// Shared assertion forms for the queue checker.
// ============================================================================
`ifndef FRONT_MIDDLE_BACK_QUEUE_MACROS_SVH
`define FRONT_MIDDLE_BACK_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMBQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FMBQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Delayed implication, disabled while reset is asserted.
`define FMBQ_ASSERT_DLY2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("%m: delayed check failed");

`endif

@@ rtl/fmbq_pkg.sv @@
// ============================================================================
// Front-middle-back queue package
// Operation codes and internal select types of the queue.
// ============================================================================
package fmbq_pkg;

    // Operation codes carried on the operation port.
    localparam logic [2:0] OP_PUSH_FRONT  = 3'd0;
    localparam logic [2:0] OP_PUSH_MIDDLE = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT   = 3'd3;
    localparam logic [2:0] OP_POP_MIDDLE  = 3'd4;
    localparam logic [2:0] OP_POP_BACK    = 3'd5;

    // Source of the result value.
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FRONT,
        RES_BACK,
        RES_EMPTY
    } res_sel_t;

    // Source of the data written into a half store.
    typedef enum logic {
        WR_VALUE,
        WR_MOVED
    } wr_sel_t;

endpackage

@@ rtl/front_middle_back_queue.sv @@
// ============================================================================
// Front-middle-back queue
// Queue with push and pop at the front, the middle and the back, kept as two
// circular halves in two synchronous memories.
// ============================================================================
//
//  Channel   Handshake          Ports
//  --------  -----------------  ---------------------------------------------
//  command   start & !busy      operation, value
//  result    done (one cycle)   result_value, empty_error, full_error,
//                               item_count
//
// Each word first reads both half stores, then writes the moved item and the
// pushed value back and registers the result.
// busy is high during the write step; a new word can be accepted in the
// cycle in which the previous result is shown on done.
// The receiver cannot stall; done is a one-cycle strobe.
// Reset clears the heads and counts; the memories need no clearing.
// ============================================================================
module front_middle_back_queue #(
    parameter int HALF_DEPTH  = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic [2:0]                                operation,
    input  logic signed [VALUE_WIDTH-1:0]             value,
    output logic                                      done,
    output logic signed [VALUE_WIDTH-1:0]             result_value,
    output logic                                      empty_error,
    output logic                                      full_error,
    output logic [$clog2(2*HALF_DEPTH+1)-1:0]         item_count
);

    localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam int NW = $clog2(2*HALF_DEPTH+1);
    localparam logic [CW-1:0] HALF_CNT = CW'(HALF_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(HALF_DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(2*HALF_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Circular index helpers.
    function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW-1:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= HALF_CNT)
        begin
            sum = sum - HALF_CNT;
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_IDX : a - AW'(1);
    endfunction

    state_t                  state_reg;
    logic [AW-1:0]           f_head_reg, f_head_next;
    logic [AW-1:0]           b_head_reg, b_head_next;
    logic [CW-1:0]           f_cnt_reg, f_cnt_next;
    logic [CW-1:0]           b_cnt_reg, b_cnt_next;

    // Write commands held for the write step.
    logic                    f_we_reg, f_we_next;
    logic                    b_we_reg, b_we_next;
    logic [AW-1:0]           f_waddr_reg, f_waddr_next;
    logic [AW-1:0]           b_waddr_reg, b_waddr_next;
    fmbq_pkg::wr_sel_t       f_wsel_reg, f_wsel_next;
    fmbq_pkg::wr_sel_t       b_wsel_reg, b_wsel_next;
    logic [VALUE_WIDTH-1:0]  value_reg;

    // Pending result.
    fmbq_pkg::res_sel_t      res_sel_reg, res_sel_next;
    logic                    empty_pend_reg, empty_pend_next;
    logic                    full_pend_reg, full_pend_next;
    logic [NW-1:0]           count_pend_reg;

    // Registered outputs.
    logic                    done_reg;
    logic [VALUE_WIDTH-1:0]  result_value_reg;
    logic                    empty_error_reg;
    logic                    full_error_reg;
    logic [NW-1:0]           item_count_reg;

    // Memories and read ports.
    logic [VALUE_WIDTH-1:0]  front_mem [HALF_DEPTH];
    logic [VALUE_WIDTH-1:0]  back_mem  [HALF_DEPTH];
    logic [VALUE_WIDTH-1:0]  front_rd_reg;
    logic [VALUE_WIDTH-1:0]  back_rd_reg;
    logic [AW-1:0]           f_raddr;
    logic [AW-1:0]           b_raddr;
    logic [VALUE_WIDTH-1:0]  f_wdata;
    logic [VALUE_WIDTH-1:0]  b_wdata;

    // Positions at the ends of both halves.
    logic [AW-1:0]           f_tail, f_last, b_tail, b_last;
    logic [NW-1:0]           total;
    logic                    odd;

    assign f_tail = idx_add(f_head_reg, f_cnt_reg);
    assign f_last = idx_add(f_head_reg, f_cnt_reg - CW'(1));
    assign b_tail = idx_add(b_head_reg, b_cnt_reg);
    assign b_last = idx_add(b_head_reg, b_cnt_reg - CW'(1));
    assign total  = NW'(f_cnt_reg) + NW'(b_cnt_reg);
    // The front half holds one item more than the back half when the count is odd.
    assign odd    = (f_cnt_reg > b_cnt_reg);

    // Decode of one operation into reads, writes and the new heads and counts.
    always_comb
    begin
        f_raddr         = f_last;
        b_raddr         = b_head_reg;
        f_we_next       = 1'b0;
        b_we_next       = 1'b0;
        f_waddr_next    = f_tail;
        b_waddr_next    = b_tail;
        f_wsel_next     = fmbq_pkg::WR_VALUE;
        b_wsel_next     = fmbq_pkg::WR_VALUE;
        f_head_next     = f_head_reg;
        b_head_next     = b_head_reg;
        f_cnt_next      = f_cnt_reg;
        b_cnt_next      = b_cnt_reg;
        res_sel_next    = fmbq_pkg::RES_ZERO;
        empty_pend_next = 1'b0;
        full_pend_next  = 1'b0;

        unique case (operation)
            fmbq_pkg::OP_PUSH_FRONT,
            fmbq_pkg::OP_PUSH_MIDDLE,
            fmbq_pkg::OP_PUSH_BACK:
            begin
                if (total >= FULL_CNT)
                begin
                    full_pend_next = 1'b1;
                end
                else if (operation == fmbq_pkg::OP_PUSH_BACK)
                begin
                    if (odd)
                    begin
                        // Value goes to the back half and balance already holds.
                        b_we_next  = 1'b1;
                        b_cnt_next = b_cnt_reg + CW'(1);
                    end
                    else if (b_cnt_reg == '0)
                    begin
                        // Empty queue: the value lands straight in the front half.
                        f_we_next  = 1'b1;
                        f_cnt_next = f_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        // The head of the back half moves to the tail of the front half.
                        f_we_next   = 1'b1;
                        f_wsel_next = fmbq_pkg::WR_MOVED;
                        b_we_next   = 1'b1;
                        b_head_next = idx_inc(b_head_reg);
                        f_cnt_next  = f_cnt_reg + CW'(1);
                    end
                end
                else
                begin
                    f_we_next = 1'b1;
                    if (operation == fmbq_pkg::OP_PUSH_FRONT)
                    begin
                        f_waddr_next = idx_dec(f_head_reg);
                        f_head_next  = f_waddr_next;
                    end
                    if (odd)
                    begin
                        // The last item of the front half moves to the back half.
                        b_we_next    = 1'b1;
                        b_waddr_next = idx_dec(b_head_reg);
                        b_wsel_next  = fmbq_pkg::WR_MOVED;
                        b_head_next  = b_waddr_next;
                        b_cnt_next   = b_cnt_reg + CW'(1);
                        if (operation == fmbq_pkg::OP_PUSH_MIDDLE)
                        begin
                            f_waddr_next = f_last;
                        end
                    end
                    else
                    begin
                        f_cnt_next = f_cnt_reg + CW'(1);
                    end
                end
            end

            fmbq_pkg::OP_POP_FRONT,
            fmbq_pkg::OP_POP_MIDDLE,
            fmbq_pkg::OP_POP_BACK:
            begin
                if (total == '0)
                begin
                    res_sel_next    = fmbq_pkg::RES_EMPTY;
                    empty_pend_next = 1'b1;
                end
                else if (operation == fmbq_pkg::OP_POP_BACK && b_cnt_reg != '0)
                begin
                    b_raddr      = b_last;
                    res_sel_next = fmbq_pkg::RES_BACK;
                    if (odd)
                    begin
                        // The last item of the front half refills the back half.
                        b_we_next    = 1'b1;
                        b_waddr_next = idx_dec(b_head_reg);
                        b_wsel_next  = fmbq_pkg::WR_MOVED;
                        b_head_next  = b_waddr_next;
                        f_cnt_next   = f_cnt_reg - CW'(1);
                    end
                    else
                    begin
                        b_cnt_next = b_cnt_reg - CW'(1);
                    end
                end
                else
                begin
                    // Pop from the front half, at its head or at its tail.
                    res_sel_next = fmbq_pkg::RES_FRONT;
                    if (operation == fmbq_pkg::OP_POP_FRONT)
                    begin
                        f_raddr      = f_head_reg;
                        f_head_next  = idx_inc(f_head_reg);
                        f_waddr_next = f_tail;
                    end
                    else
                    begin
                        f_waddr_next = f_last;
                    end
                    if (odd)
                    begin
                        f_cnt_next = f_cnt_reg - CW'(1);
                    end
                    else
                    begin
                        // The head of the back half moves to the tail of the front half.
                        f_we_next   = 1'b1;
                        f_wsel_next = fmbq_pkg::WR_MOVED;
                        b_head_next = idx_inc(b_head_reg);
                        b_cnt_next  = b_cnt_reg - CW'(1);
                    end
                end
            end

            default:
            begin
                res_sel_next = fmbq_pkg::RES_ZERO;
            end
        endcase
    end

    // Control state, pending command and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            f_head_reg <= '0;
            b_head_reg <= '0;
            f_cnt_reg  <= '0;
            b_cnt_reg  <= '0;
            f_we_reg   <= 1'b0;
            b_we_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg      <= ST_EXEC;
                        f_head_reg     <= f_head_next;
                        b_head_reg     <= b_head_next;
                        f_cnt_reg      <= f_cnt_next;
                        b_cnt_reg      <= b_cnt_next;
                        f_we_reg       <= f_we_next;
                        b_we_reg       <= b_we_next;
                        f_waddr_reg    <= f_waddr_next;
                        b_waddr_reg    <= b_waddr_next;
                        f_wsel_reg     <= f_wsel_next;
                        b_wsel_reg     <= b_wsel_next;
                        value_reg      <= value;
                        res_sel_reg    <= res_sel_next;
                        empty_pend_reg <= empty_pend_next;
                        full_pend_reg  <= full_pend_next;
                        count_pend_reg <= NW'(f_cnt_next) + NW'(b_cnt_next);
                    end
                    else
                    begin
                        f_we_reg <= 1'b0;
                        b_we_reg <= 1'b0;
                    end
                end

                ST_EXEC:
                begin
                    state_reg       <= ST_IDLE;
                    f_we_reg        <= 1'b0;
                    b_we_reg        <= 1'b0;
                    done_reg        <= 1'b1;
                    empty_error_reg <= empty_pend_reg;
                    full_error_reg  <= full_pend_reg;
                    item_count_reg  <= count_pend_reg;
                    unique case (res_sel_reg)
                        fmbq_pkg::RES_ZERO:  result_value_reg <= '0;
                        fmbq_pkg::RES_FRONT: result_value_reg <= front_rd_reg;
                        fmbq_pkg::RES_BACK:  result_value_reg <= back_rd_reg;
                        fmbq_pkg::RES_EMPTY: result_value_reg <= '1;
                        default:             result_value_reg <= '0;
                    endcase
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Write data: the pushed value or the item read from the other half.
    assign f_wdata = (f_wsel_reg == fmbq_pkg::WR_MOVED) ? back_rd_reg  : value_reg;
    assign b_wdata = (b_wsel_reg == fmbq_pkg::WR_MOVED) ? front_rd_reg : value_reg;

    // Front half store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (f_we_reg)
        begin
            front_mem[f_waddr_reg] <= f_wdata;
        end
        front_rd_reg <= front_mem[f_raddr];
    end

    // Back half store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (b_we_reg)
        begin
            back_mem[b_waddr_reg] <= b_wdata;
        end
        back_rd_reg <= back_mem[b_raddr];
    end

    assign busy         = (state_reg == ST_EXEC);
    assign done         = done_reg;
    assign result_value = result_value_reg;
    assign empty_error  = empty_error_reg;
    assign full_error   = full_error_reg;
    assign item_count   = item_count_reg;

endmodule

@@ rtl/fmbq_checker.sv @@
// ============================================================================
// Front-middle-back queue checker
// Port-level assertions on command timing and result consistency.
// ============================================================================
`include "front_middle_back_queue_macros.svh"

module fmbq_checker #(
    parameter int HALF_DEPTH  = 512,
    parameter int VALUE_WIDTH = 32
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic [2:0]                            operation,
    input logic                                  done,
    input logic [VALUE_WIDTH-1:0]                result_value,
    input logic                                  empty_error,
    input logic                                  full_error,
    input logic [$clog2(2*HALF_DEPTH+1)-1:0]     item_count
);

    localparam int NW = $clog2(2*HALF_DEPTH+1);

    logic accepted;
    logic push_word;

    assign accepted  = start && !busy;
    assign push_word = (operation == fmbq_pkg::OP_PUSH_FRONT)
                    || (operation == fmbq_pkg::OP_PUSH_MIDDLE)
                    || (operation == fmbq_pkg::OP_PUSH_BACK);

    // Every accepted word gives its result on done, after the execute state.
    `FMBQ_ASSERT_DLY2(a_result_timing, clk, rst_n, accepted, done)

    // Results never come in back-to-back cycles.
    `FMBQ_ASSERT_NXT(a_done_spacing, clk, rst_n, done, !done)

    // A pop on an empty queue reports all ones and leaves the queue empty.
    `FMBQ_ASSERT_IMP(a_empty_result, clk, rst_n, done && empty_error, (result_value == '1) && (item_count == '0) && !full_error)

    // A dropped push reports a full queue.
    `FMBQ_ASSERT_IMP(a_full_result, clk, rst_n, done && full_error, (item_count == NW'(2*HALF_DEPTH)) && (result_value == '0))

    // A push never reports an empty queue.
    `FMBQ_ASSERT_DLY2(a_push_not_empty, clk, rst_n, accepted && push_word, !empty_error)

endmodule

bind front_middle_back_queue fmbq_checker #(
    .HALF_DEPTH  (HALF_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_fmbq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .done         (done),
    .result_value (result_value),
    .empty_error  (empty_error),
    .full_error   (full_error),
    .item_count   (item_count)
);

@@ dv/front_middle_back_queue_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Front-middle-back queue testbench
// Drives push and pop words at the front, middle and back of the queue, with
// random idle bursts between them. A predictor keeps its own two-half copy of
// the queue. Every result strobe is compared, field by field, with the oldest
// predicted result. The run walks a directed table first, and then random
// phases that fill the queue past full and drain it again.
// ============================================================================
module front_middle_back_queue_tb;

    localparam int HALF_DEPTH  = 512;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = $clog2(2*HALF_DEPTH+1);
    localparam int FULL_COUNT  = 2*HALF_DEPTH;

    // Codes that the block treats as no operation.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Value reported by a pop that finds the queue empty.
    localparam logic [VALUE_WIDTH-1:0] POP_EMPTY_VALUE = '1;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   empty_err;
        logic                   full_err;
        logic [COUNT_WIDTH-1:0] count;
    } queue_outcome_t;

    typedef struct packed {
        logic [2:0]             op;
        logic [VALUE_WIDTH-1:0] data;
        logic                   typed;
        queue_outcome_t         outcome;
    } stim_row_t;

    localparam queue_outcome_t NO_OUTCOME = '0;
    localparam int NUM_DIRECTED = 23;

    // Directed words. Rows marked typed carry a result that is known up
    // front; the other rows are checked against the predictor.
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // Pops and spare codes on the empty queue after reset.
        '{fmbq_pkg::OP_POP_FRONT,   32'h0000_0000, 1'b1,
          '{POP_EMPTY_VALUE, 1'b1, 1'b0, 11'd0}},
        '{fmbq_pkg::OP_POP_MIDDLE,  32'h1234_5678, 1'b1,
          '{POP_EMPTY_VALUE, 1'b1, 1'b0, 11'd0}},
        '{fmbq_pkg::OP_POP_BACK,    32'hFFFF_FFFF, 1'b1,
          '{POP_EMPTY_VALUE, 1'b1, 1'b0, 11'd0}},
        '{OP_SPARE_LO,              32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, 1'b0, 11'd0}},
        '{OP_SPARE_HI,              32'h7FFF_FFFF, 1'b1, '{32'd0, 1'b0, 1'b0, 11'd0}},
        // Extreme values pushed at every position.
        '{fmbq_pkg::OP_PUSH_BACK,   32'h7FFF_FFFF, 1'b1, '{32'd0, 1'b0, 1'b0, 11'd1}},
        '{fmbq_pkg::OP_PUSH_FRONT,  32'h8000_0000, 1'b1, '{32'd0, 1'b0, 1'b0, 11'd2}},
        '{fmbq_pkg::OP_PUSH_MIDDLE, 32'h0000_0000, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_PUSH_MIDDLE, 32'hFFFF_FFFF, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_PUSH_FRONT,  32'h0000_0001, 1'b0, NO_OUTCOME},
        '{OP_SPARE_LO,              32'h5555_5555, 1'b0, NO_OUTCOME},
        // Drain from every position down to one item.
        '{fmbq_pkg::OP_POP_MIDDLE,  32'hAAAA_AAAA, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_POP_BACK,    32'h0000_0000, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_POP_FRONT,   32'hFFFF_FFFF, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_POP_MIDDLE,  32'h0000_0000, 1'b0, NO_OUTCOME},
        // Pop back with a single item held in the front half.
        '{fmbq_pkg::OP_POP_BACK,    32'h0000_0000, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_POP_MIDDLE,  32'h0000_0000, 1'b1,
          '{POP_EMPTY_VALUE, 1'b1, 1'b0, 11'd0}},
        '{fmbq_pkg::OP_PUSH_BACK,   32'h5555_5555, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_POP_BACK,    32'h0000_0000, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_PUSH_MIDDLE, 32'hAAAA_AAAA, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_POP_MIDDLE,  32'h0000_0000, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_PUSH_FRONT,  32'h1234_5678, 1'b0, NO_OUTCOME},
        '{fmbq_pkg::OP_POP_FRONT,   32'h0000_0000, 1'b0, NO_OUTCOME}
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [2:0]                    operation;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          done;
    logic signed [VALUE_WIDTH-1:0] result_value;
    logic                          empty_error;
    logic                          full_error;
    logic [COUNT_WIDTH-1:0]        item_count;

    // Predictor state: the two circular halves of the queue.
    logic [VALUE_WIDTH-1:0] front_mem [HALF_DEPTH];
    logic [VALUE_WIDTH-1:0] back_mem  [HALF_DEPTH];
    int                     front_head  = 0;
    int                     front_count = 0;
    int                     back_head   = 0;
    int                     back_count  = 0;

    queue_outcome_t expected_outcomes [$];
    int             mismatches  = 0;
    bit             reached_full = 1'b0;

    front_middle_back_queue #(
        .HALF_DEPTH  (HALF_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .empty_error  (empty_error),
        .full_error   (full_error),
        .item_count   (item_count)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Move the last item of the front half to the head of the back half.
    function automatic void shift_tail_to_back();
        logic [VALUE_WIDTH-1:0] moved;
        front_count = front_count - 1;
        moved = front_mem[(front_head + front_count) % HALF_DEPTH];
        back_head = (back_head + HALF_DEPTH - 1) % HALF_DEPTH;
        back_mem[back_head] = moved;
        back_count = back_count + 1;
    endfunction

    // Move the first item of the back half to the end of the front half.
    function automatic void shift_head_to_front();
        logic [VALUE_WIDTH-1:0] moved;
        moved = back_mem[back_head];
        back_head = (back_head + 1) % HALF_DEPTH;
        back_count = back_count - 1;
        front_mem[(front_head + front_count) % HALF_DEPTH] = moved;
        front_count = front_count + 1;
    endfunction

    // The front half holds ceil(n/2) items once this returns.
    function automatic void rebalance_halves();
        if (back_count > front_count)
            shift_head_to_front();
        if (front_count > back_count + 1)
            shift_tail_to_back();
    endfunction

    // Apply one word to the predicted queue and return its result.
    function automatic queue_outcome_t predict_outcome(input logic [2:0] op,
                                                       input logic [VALUE_WIDTH-1:0] data);
        queue_outcome_t outcome;
        int             held;
        outcome = NO_OUTCOME;
        held    = front_count + back_count;
        case (op)
            fmbq_pkg::OP_PUSH_FRONT, fmbq_pkg::OP_PUSH_MIDDLE, fmbq_pkg::OP_PUSH_BACK:
            begin
                if (held >= FULL_COUNT)
                    outcome.full_err = 1'b1;
                else
                begin
                    if (op == fmbq_pkg::OP_PUSH_BACK)
                    begin
                        back_mem[(back_head + back_count) % HALF_DEPTH] = data;
                        back_count = back_count + 1;
                    end
                    else
                    begin
                        // Make room in the front half before inserting there.
                        if (front_count > back_count)
                            shift_tail_to_back();
                        if (op == fmbq_pkg::OP_PUSH_FRONT)
                        begin
                            front_head = (front_head + HALF_DEPTH - 1) % HALF_DEPTH;
                            front_mem[front_head] = data;
                        end
                        else
                            front_mem[(front_head + front_count) % HALF_DEPTH] = data;
                        front_count = front_count + 1;
                    end
                    rebalance_halves();
                end
            end
            fmbq_pkg::OP_POP_FRONT, fmbq_pkg::OP_POP_MIDDLE, fmbq_pkg::OP_POP_BACK:
            begin
                if (held == 0)
                begin
                    outcome.value     = POP_EMPTY_VALUE;
                    outcome.empty_err = 1'b1;
                end
                else
                begin
                    if (op == fmbq_pkg::OP_POP_FRONT)
                    begin
                        outcome.value = front_mem[front_head];
                        front_head  = (front_head + 1) % HALF_DEPTH;
                        front_count = front_count - 1;
                    end
                    // A lone item sits in the front half, so pop back takes it there.
                    else if (op == fmbq_pkg::OP_POP_MIDDLE || back_count == 0)
                    begin
                        front_count = front_count - 1;
                        outcome.value = front_mem[(front_head + front_count) % HALF_DEPTH];
                    end
                    else
                    begin
                        back_count = back_count - 1;
                        outcome.value = back_mem[(back_head + back_count) % HALF_DEPTH];
                    end
                    rebalance_halves();
                end
            end
            default:
            begin
            end
        endcase
        outcome.count = COUNT_WIDTH'(front_count + back_count);
        return outcome;
    endfunction

    function automatic void report_field(input string field,
                                         input logic [VALUE_WIDTH-1:0] want,
                                         input logic [VALUE_WIDTH-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d actual %0d",
                     $time, field, $signed(want), $signed(got));
            mismatches++;
        end
    endfunction

    // Value mix: extremes, small numbers and fully random words.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // Pick an operation; push_pct sets the share of pushes among pushes and pops.
    function automatic logic [2:0] pick_op(input int push_pct);
        if ($urandom_range(0, 49) == 0)
            return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
        if ($urandom_range(0, 99) < push_pct)
        begin
            case ($urandom_range(0, 2))
                0:       return fmbq_pkg::OP_PUSH_FRONT;
                1:       return fmbq_pkg::OP_PUSH_MIDDLE;
                default: return fmbq_pkg::OP_PUSH_BACK;
            endcase
        end
        case ($urandom_range(0, 2))
            0:       return fmbq_pkg::OP_POP_FRONT;
            1:       return fmbq_pkg::OP_POP_MIDDLE;
            default: return fmbq_pkg::OP_POP_BACK;
        endcase
    endfunction

    // Present one word, hold it until the block takes it, then predict its result.
    task automatic send_word(input logic [2:0] op, input logic [VALUE_WIDTH-1:0] data,
                             input logic typed, input queue_outcome_t typed_outcome);
        queue_outcome_t predicted;
        start     <= 1'b1;
        operation <= op;
        value     <= data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_outcome(op, data);
        expected_outcomes.insert(expected_outcomes.size(), typed ? typed_outcome : predicted);
        if (predicted.count == COUNT_WIDTH'(FULL_COUNT))
            reached_full = 1'b1;
    endtask

    // Drop start for a short burst; the other inputs carry noise meanwhile.
    task automatic idle_burst();
        start     <= 1'b0;
        operation <= 3'($urandom_range(0, 7));
        value     <= $urandom();
        repeat ($urandom_range(1, 7))
            @(posedge clk);
    endtask

    task automatic run_random(input int words, input int push_pct, input bit gaps);
        for (int i = 0; i < words; i++)
        begin
            send_word(pick_op(push_pct), pick_value(), 1'b0, NO_OUTCOME);
            if (gaps && $urandom_range(0, 3) == 0)
                idle_burst();
        end
    endtask

    // Stimulus: reset, directed table, balanced traffic, then fill past full and drain.
    initial
    begin : stimulus
        bit gaps_on;
        int wait_cycles;
        gaps_on   = 1'b1;
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = fmbq_pkg::OP_PUSH_FRONT;
        value     = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < NUM_DIRECTED; row++)
        begin
            send_word(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].data,
                      DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].outcome);
            if ($urandom_range(0, 2) == 0)
                idle_burst();
        end

        // Balanced traffic around the empty queue.
        run_random(100, 55, 1'b1);
        run_random(100, 55, 1'b0);

        // Fill until full, alternating stretches with and without gaps.
        while (!reached_full)
        begin
            run_random(20, 97, gaps_on);
            gaps_on = !gaps_on;
        end

        // Hover near full so that pushes get dropped, then drain.
        run_random(60, 75, 1'b1);
        run_random(60, 20, 1'b1);
        run_random(150, 20, 1'b0);

        // Wait for the outstanding results, then check that none is left over.
        start <= 1'b0;
        wait_cycles = 0;
        while (expected_outcomes.size() != 0 && wait_cycles < 100)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4)
            @(posedge clk);

        if (expected_outcomes.size() != 0)
        begin
            $display("%0t: pending results expected 0 actual %0d",
                     $time, expected_outcomes.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Compare each result strobe with the oldest predicted result.
    always @(posedge clk)
    begin : check_results
        queue_outcome_t want;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: result with nothing expected: value %0d count %0d",
                         $time, result_value, item_count);
                mismatches++;
            end
            else
            begin
                want = expected_outcomes[0];
                expected_outcomes.delete(0);
                report_field("result_value", want.value, result_value);
                report_field("empty_error", 32'(want.empty_err), 32'(empty_error));
                report_field("full_error", 32'(want.full_err), 32'(full_error));
                report_field("item_count", 32'(want.count), 32'(item_count));
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fmbq_pkg.sv
rtl/front_middle_back_queue.sv
rtl/fmbq_checker.sv
dv/front_middle_back_queue_tb.sv
